FILE: design/cbe_pkg.sv
// ----------------------------------------------------------------------------
// cbe_pkg: shared types and constants of the cubic Bezier evaluator
// Holds the register index codes, the fixed field widths, the slope limit and
// the stage load-enable bundle that the pipeline control hands to the datapath.
// ----------------------------------------------------------------------------
package cbe_pkg;

  // Default number of fraction bits of the curve parameter.
  localparam int T_FRAC_BITS_DEF = 16;

  // Fixed field widths.
  localparam int COORD_W = 32;
  localparam int SLOPE_W = 35;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int CFG_REGS = 8;
  localparam int CFG_IDX_W = 3;

  // Slope saturation bound, +-(3 * 2^32 - 3).
  localparam logic [SLOPE_W-1:0] SLOPE_LIMIT     = 35'h2_FFFF_FFFD;
  localparam logic [SLOPE_W-1:0] SLOPE_LIMIT_NEG = 35'h5_0000_0003;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X  = 3'd0,
    REG_START_Y  = 3'd1,
    REG_CTRL_A_X = 3'd2,
    REG_CTRL_A_Y = 3'd3,
    REG_CTRL_B_X = 3'd4,
    REG_CTRL_B_Y = 3'd5,
    REG_END_X    = 3'd6,
    REG_END_Y    = 3'd7
  } cfg_reg_t;

  // Load enables of the six pipeline stages.
  typedef struct packed {
    logic s0;
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

FILE: design/cbe_weights.sv
// ----------------------------------------------------------------------------
// cbe_weights: parameter clamp and Bernstein weight pipeline
// Stage 0 clamps t and forms 1 - t, stage 1 forms the second-order terms,
// stage 2 forms the cubic point weights and the derivative weights.
// ----------------------------------------------------------------------------
module cbe_weights
  import cbe_pkg::*;
#(
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  stage_en_t              en,
  input  logic [T_FRAC_BITS:0]   t_in,
  output logic [T_FRAC_BITS:0]   w0,
  output logic [T_FRAC_BITS:0]   w1,
  output logic [T_FRAC_BITS:0]   w2,
  output logic [T_FRAC_BITS:0]   w3,
  output logic [T_FRAC_BITS+1:0] d0,
  output logic [T_FRAC_BITS+1:0] d1,
  output logic [T_FRAC_BITS+1:0] d2
);

  localparam int TW = T_FRAC_BITS + 1;
  localparam int DW = T_FRAC_BITS + 2;
  localparam int NW = 2 * TW;
  localparam int XW = 2 * TW + 2;
  localparam logic [TW-1:0] ONE   = {1'b1, {T_FRAC_BITS{1'b0}}};
  localparam logic [NW-1:0] RND_N = NW'(1) << (T_FRAC_BITS - 1);
  localparam logic [XW-1:0] RND_X = XW'(1) << (T_FRAC_BITS - 1);

  logic [TW-1:0] t_clip;
  logic [TW-1:0] t0, ti0;
  logic [TW-1:0] t1, ti1, tt1, ii1, it1;
  logic [NW-1:0] pr_tt, pr_ii, pr_it, pr_w0, pr_w3;
  logic [XW-1:0] pr_w1, pr_w2;
  logic [TW+1:0] m3ii, m3it, m3tt;
  logic [TW+2:0] m6it;

  // Stage 0: clamp t to one and form its complement.
  assign t_clip = (t_in > ONE) ? ONE : t_in;

  always_ff @(posedge clk) begin
    if (en.s0) begin
      t0  <= t_clip;
      ti0 <= ONE - t_clip;
    end
  end

  // Stage 1: second-order terms, rounded back to the parameter format.
  always_comb begin
    pr_tt = NW'(t0) * NW'(t0) + RND_N;
    pr_ii = NW'(ti0) * NW'(ti0) + RND_N;
    pr_it = NW'(t0) * NW'(ti0) + RND_N;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      t1  <= t0;
      ti1 <= ti0;
      tt1 <= pr_tt[T_FRAC_BITS +: TW];
      ii1 <= pr_ii[T_FRAC_BITS +: TW];
      it1 <= pr_it[T_FRAC_BITS +: TW];
    end
  end

  // Stage 2: cubic weights and derivative weights.
  always_comb begin
    m3ii  = (TW+2)'({ii1, 1'b0}) + (TW+2)'(ii1);
    m3it  = (TW+2)'({it1, 1'b0}) + (TW+2)'(it1);
    m3tt  = (TW+2)'({tt1, 1'b0}) + (TW+2)'(tt1);
    m6it  = (TW+3)'({it1, 2'b00}) + (TW+3)'({it1, 1'b0});
    pr_w0 = NW'(ii1) * NW'(ti1) + RND_N;
    pr_w1 = XW'(m3ii) * XW'(t1) + RND_X;
    pr_w2 = XW'(m3it) * XW'(t1) + RND_X;
    pr_w3 = NW'(tt1) * NW'(t1) + RND_N;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      w0 <= pr_w0[T_FRAC_BITS +: TW];
      w1 <= pr_w1[T_FRAC_BITS +: TW];
      w2 <= pr_w2[T_FRAC_BITS +: TW];
      w3 <= pr_w3[T_FRAC_BITS +: TW];
      d0 <= m3ii[DW-1:0];
      d1 <= m6it[DW-1:0];
      d2 <= m3tt[DW-1:0];
    end
  end

endmodule

FILE: design/cbe_axis.sv
// ----------------------------------------------------------------------------
// cbe_axis: weighted sums of one coordinate axis
// Multiplies the weights with the control points and their differences,
// rounds each product, then sums and saturates point and slope.
// ----------------------------------------------------------------------------
module cbe_axis
  import cbe_pkg::*;
#(
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  stage_en_t                 en,
  input  logic [T_FRAC_BITS:0]      w0,
  input  logic [T_FRAC_BITS:0]      w1,
  input  logic [T_FRAC_BITS:0]      w2,
  input  logic [T_FRAC_BITS:0]      w3,
  input  logic [T_FRAC_BITS+1:0]    d0,
  input  logic [T_FRAC_BITS+1:0]    d1,
  input  logic [T_FRAC_BITS+1:0]    d2,
  input  logic signed [COORD_W-1:0] p0,
  input  logic signed [COORD_W-1:0] p1,
  input  logic signed [COORD_W-1:0] p2,
  input  logic signed [COORD_W-1:0] p3,
  output logic [COORD_W-1:0]        point,
  output logic [SLOPE_W-1:0]        slope
);

  localparam int TW  = T_FRAC_BITS + 1;
  localparam int DW  = T_FRAC_BITS + 2;
  localparam int PW  = TW + 1 + COORD_W;
  localparam int SW  = DW + 1 + DIFF_W;
  localparam int PTW = PW - T_FRAC_BITS;
  localparam int STW = SW - T_FRAC_BITS;
  localparam int PSW = PTW + 2;
  localparam int SSW = STW + 2;
  localparam logic signed [PW-1:0] PRND = PW'(1) << (T_FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SRND = SW'(1) << (T_FRAC_BITS - 1);
  localparam logic signed [PSW-1:0] PT_MAX = {{(PSW-COORD_W){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [PSW-1:0] PT_MIN = {{(PSW-COORD_W){1'b1}}, 32'h8000_0000};
  localparam logic signed [SSW-1:0] SL_MAX = {{(SSW-SLOPE_W){1'b0}}, SLOPE_LIMIT};
  localparam logic signed [SSW-1:0] SL_MIN = {{(SSW-SLOPE_W){1'b1}}, SLOPE_LIMIT_NEG};

  logic signed [DIFF_W-1:0] df0, df1, df2;
  logic signed [PW-1:0]     pm [4];
  logic signed [SW-1:0]     sm [3];
  logic signed [PW-1:0]     pr [4];
  logic signed [SW-1:0]     sr [3];
  logic signed [PTW-1:0]    pt [4];
  logic signed [STW-1:0]    st [3];
  logic signed [PSW-1:0]    psum;
  logic signed [SSW-1:0]    ssum;

  // Control-point differences follow the registers; they settle long before
  // an item reaches the multipliers.
  always_ff @(posedge clk) begin
    df0 <= DIFF_W'(p1) - DIFF_W'(p0);
    df1 <= DIFF_W'(p2) - DIFF_W'(p1);
    df2 <= DIFF_W'(p3) - DIFF_W'(p2);
  end

  // Stage 3: one multiplier per term.
  always_ff @(posedge clk) begin
    if (en.s3) begin
      pm[0] <= PW'($signed({1'b0, w0})) * PW'(p0);
      pm[1] <= PW'($signed({1'b0, w1})) * PW'(p1);
      pm[2] <= PW'($signed({1'b0, w2})) * PW'(p2);
      pm[3] <= PW'($signed({1'b0, w3})) * PW'(p3);
      sm[0] <= SW'($signed({1'b0, d0})) * SW'(df0);
      sm[1] <= SW'($signed({1'b0, d1})) * SW'(df1);
      sm[2] <= SW'($signed({1'b0, d2})) * SW'(df2);
    end
  end

  // Stage 4: round each product to nearest, halves upward.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pr[k] = pm[k] + PRND;
    end
    for (int k = 0; k < 3; k++) begin
      sr[k] = sm[k] + SRND;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      for (int k = 0; k < 4; k++) begin
        pt[k] <= $signed(pr[k][PW-1:T_FRAC_BITS]);
      end
      for (int k = 0; k < 3; k++) begin
        st[k] <= $signed(sr[k][SW-1:T_FRAC_BITS]);
      end
    end
  end

  // Stage 5: sum the rounded terms and saturate.
  always_comb begin
    psum = PSW'(pt[0]) + PSW'(pt[1]) + PSW'(pt[2]) + PSW'(pt[3]);
    ssum = SSW'(st[0]) + SSW'(st[1]) + SSW'(st[2]);
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      if (psum > PT_MAX) begin
        point <= PT_MAX[COORD_W-1:0];
      end else if (psum < PT_MIN) begin
        point <= PT_MIN[COORD_W-1:0];
      end else begin
        point <= psum[COORD_W-1:0];
      end
      if (ssum > SL_MAX) begin
        slope <= SL_MAX[SLOPE_W-1:0];
      end else if (ssum < SL_MIN) begin
        slope <= SL_MIN[SLOPE_W-1:0];
      end else begin
        slope <= ssum[SLOPE_W-1:0];
      end
    end
  end

endmodule

FILE: design/cubic_bezier_evaluator.sv
// ----------------------------------------------------------------------------
// cubic_bezier_evaluator: pipelined 2D cubic Bezier point and slope unit
// Control points sit in eight Q16.16 registers; each parameter transaction on
// the slave stream yields one point and first-derivative transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Write the control points through cfg_wr_en / cfg_index / cfg_data while
//   the block is idle; index 0..7 is start_x, start_y, ctrl_a_x, ctrl_a_y,
//   ctrl_b_x, ctrl_b_y, end_x, end_y. Then stream parameters t (unsigned
//   Q1.T_FRAC_BITS, clamped to 1.0) on s_axis_*. Each accepted transaction
//   gives one transaction on m_axis_* with point_x, point_y (Q16.16, saturated
//   to 32 bits) and slope_x, slope_y (Q19.16, saturated to +-12884901885).
//   The datapath is six register stages: clamp, second-order terms, weights,
//   multipliers, rounding, sum and saturate. A result is registered through
//   the stages in order and shows on m_axis_tvalid once the last one holds it.
//   One transaction is taken per cycle unless a receiver stall has filled them.
//   Every stage holds its own valid bit and loads when it is empty or when the
//   stage after it moves, so a stalled receiver only fills the pipeline: the
//   slave side keeps accepting until all six stages hold an item.
//   Synchronous reset clears the valid bits and zeroes the control points.
// ----------------------------------------------------------------------------
module cubic_bezier_evaluator
  import cbe_pkg::*;
#(
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port.
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_W-1:0]     cfg_data,
  // Parameter stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: param_t, zero padding above.
  input  logic [((T_FRAC_BITS+8)/8)*8-1:0] s_axis_tdata,
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: point_x[31:0], point_y[63:32], slope_x[98:64], slope_y[133:99],
  // zero padding [135:134].
  output logic [135:0]           m_axis_tdata
);

  localparam int TW = T_FRAC_BITS + 1;
  localparam int DW = T_FRAC_BITS + 2;

  logic signed [COORD_W-1:0] ctrl_pt [CFG_REGS];
  logic [5:0]     vld;
  stage_en_t      en;
  logic [TW-1:0]  w0, w1, w2, w3;
  logic [DW-1:0]  d0, d1, d2;
  logic [COORD_W-1:0] point_x, point_y;
  logic [SLOPE_W-1:0] slope_x, slope_y;

  // Control-point registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CFG_REGS; k++) begin
        ctrl_pt[k] <= '0;
      end
    end else if (cfg_wr_en) begin
      ctrl_pt[cfg_index] <= cfg_data;
    end
  end

  // Stage load enables: a stage loads when empty or when its successor moves.
  always_comb begin
    en.s5 = !vld[5] || m_axis_tready;
    en.s4 = !vld[4] || en.s5;
    en.s3 = !vld[3] || en.s4;
    en.s2 = !vld[2] || en.s3;
    en.s1 = !vld[1] || en.s2;
    en.s0 = !vld[0] || en.s1;
  end

  assign s_axis_tready = en.s0;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en.s0) vld[0] <= s_axis_tvalid;
      if (en.s1) vld[1] <= vld[0];
      if (en.s2) vld[2] <= vld[1];
      if (en.s3) vld[3] <= vld[2];
      if (en.s4) vld[4] <= vld[3];
      if (en.s5) vld[5] <= vld[4];
    end
  end

  cbe_weights #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_weights (
    .clk  (clk),
    .en   (en),
    .t_in (s_axis_tdata[TW-1:0]),
    .w0   (w0),
    .w1   (w1),
    .w2   (w2),
    .w3   (w3),
    .d0   (d0),
    .d1   (d1),
    .d2   (d2)
  );

  cbe_axis #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_axis_x (
    .clk   (clk),
    .en    (en),
    .w0    (w0),
    .w1    (w1),
    .w2    (w2),
    .w3    (w3),
    .d0    (d0),
    .d1    (d1),
    .d2    (d2),
    .p0    (ctrl_pt[REG_START_X]),
    .p1    (ctrl_pt[REG_CTRL_A_X]),
    .p2    (ctrl_pt[REG_CTRL_B_X]),
    .p3    (ctrl_pt[REG_END_X]),
    .point (point_x),
    .slope (slope_x)
  );

  cbe_axis #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_axis_y (
    .clk   (clk),
    .en    (en),
    .w0    (w0),
    .w1    (w1),
    .w2    (w2),
    .w3    (w3),
    .d0    (d0),
    .d1    (d1),
    .d2    (d2),
    .p0    (ctrl_pt[REG_START_Y]),
    .p1    (ctrl_pt[REG_CTRL_A_Y]),
    .p2    (ctrl_pt[REG_CTRL_B_Y]),
    .p3    (ctrl_pt[REG_END_Y]),
    .point (point_y),
    .slope (slope_y)
  );

  // Output transaction.
  assign m_axis_tvalid = vld[5];
  assign m_axis_tdata  = {2'b00, slope_y, slope_x, point_y, point_x};

`ifndef SYNTHESIS
  // An empty first stage always takes a new transaction.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> s_axis_tready)
    else $error("input stalled with an empty first stage");

  // A stalled output with a full stage behind it keeps both items.
  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    (vld[5] && vld[4] && !m_axis_tready) |=> (vld[5] && vld[4]))
    else $error("item lost while the output was stalled");

  // A taken result with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (vld[5] && m_axis_tready && !vld[4]) |=> !m_axis_tvalid)
    else $error("result repeated after it was taken");
`endif

endmodule

FILE: verif/cubic_bezier_evaluator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cubic_bezier_evaluator_tb: self-checking bench for the Bezier evaluator
// Loads control points through the write port and streams curve parameters
// into the block. A behavioral predictor computes the point and slope of each
// accepted parameter, and every result transaction is checked field by field
// in arrival order. Random gaps, random receiver stalls and one long receiver
// hold-off exercise the pipeline's flow control.
// ----------------------------------------------------------------------------
module cubic_bezier_evaluator_tb;
  import cbe_pkg::*;

  localparam int T_FRAC     = T_FRAC_BITS_DEF;
  localparam int PARAM_W    = T_FRAC + 1;
  localparam int S_TDATA_W  = ((T_FRAC + 8) / 8) * 8;
  localparam longint unsigned T_ONE = 64'd1 << T_FRAC;
  localparam longint HALF_LSB = 64'sd1 <<< (T_FRAC - 1);
  localparam longint POINT_MAX = 64'sd2147483647;
  localparam longint POINT_MIN = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 200000;

  // One result, laid out as on the result stream from bit 133 down.
  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope_y;
    logic signed [SLOPE_W-1:0] slope_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_x;
  } curve_sample_t;

  typedef logic [COORD_W-1:0] curve_regs_t [CFG_REGS];

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [COORD_W-1:0]     cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [135:0]           m_axis_tdata;

  // Predictor copy of the control points, sign extended.
  longint        ctrl_pt [CFG_REGS];
  curve_sample_t pending_samples [$];
  int            mismatch_count;
  int            cycle_count;
  bit            source_gaps_on;
  bit            sink_stalls_on;
  int            sink_hold_cycles;

  cubic_bezier_evaluator uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock generation.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** cubic_bezier_evaluator: FAILED **");
      $finish;
    end
  end

  // Unsigned product scaled back to Q.F, rounded to nearest.
  function automatic longint unsigned mul_q(input longint unsigned a,
                                            input longint unsigned b);
    return (a * b + longint'(HALF_LSB)) >> T_FRAC;
  endfunction

  // Signed value scaled back to Q.F, halves rounded toward plus infinity.
  function automatic longint round_q(input longint v);
    return (v + HALF_LSB) >>> T_FRAC;
  endfunction

  // Curve point and first derivative at parameter t.
  function automatic curve_sample_t eval_bezier(input logic [PARAM_W-1:0] param_t);
    longint unsigned t, ti, tt, ii, it;
    longint w [4];
    longint d [3];
    longint p0, p1, p2, p3, pt, sl;
    curve_sample_t s;
    t = param_t;
    if (t > T_ONE) t = T_ONE;
    ti = T_ONE - t;
    tt = mul_q(t, t);
    ii = mul_q(ti, ti);
    it = mul_q(t, ti);
    w[0] = longint'(mul_q(ii, ti));
    w[1] = longint'(mul_q(3 * ii, t));
    w[2] = longint'(mul_q(3 * it, t));
    w[3] = longint'(mul_q(tt, t));
    d[0] = longint'(3 * ii);
    d[1] = longint'(6 * it);
    d[2] = longint'(3 * tt);
    for (int axis = 0; axis < 2; axis++) begin
      p0 = ctrl_pt[REG_START_X + axis];
      p1 = ctrl_pt[REG_CTRL_A_X + axis];
      p2 = ctrl_pt[REG_CTRL_B_X + axis];
      p3 = ctrl_pt[REG_END_X + axis];
      pt = round_q(w[0] * p0) + round_q(w[1] * p1) + round_q(w[2] * p2)
         + round_q(w[3] * p3);
      sl = round_q(d[0] * (p1 - p0)) + round_q(d[1] * (p2 - p1))
         + round_q(d[2] * (p3 - p2));
      if (pt > POINT_MAX) pt = POINT_MAX;
      if (pt < POINT_MIN) pt = POINT_MIN;
      if (sl > longint'(SLOPE_LIMIT)) sl = longint'(SLOPE_LIMIT);
      if (sl < -longint'(SLOPE_LIMIT)) sl = -longint'(SLOPE_LIMIT);
      if (axis == 0) begin
        s.point_x = pt[COORD_W-1:0];
        s.slope_x = sl[SLOPE_W-1:0];
      end else begin
        s.point_y = pt[COORD_W-1:0];
        s.slope_y = sl[SLOPE_W-1:0];
      end
    end
    return s;
  endfunction

  // Write all eight control-point registers on consecutive cycles.
  task automatic load_curve(input curve_regs_t pts);
    for (int i = 0; i < CFG_REGS; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= pts[i];
      @(posedge clk);
      ctrl_pt[i] = longint'(signed'(pts[i]));
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Offer one parameter and record its expected result once accepted.
  task automatic send_param(input logic [PARAM_W-1:0] param_t);
    int gap;
    gap = source_gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(param_t);
    do @(posedge clk); while (!s_axis_tready);
    pending_samples.push_back(eval_bezier(param_t));
  endtask

  // Stop offering parameters until every outstanding result has come back.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_samples.size() != 0);
  endtask

  // Parameter mix: mostly inside the curve, some clamped, some at the ends.
  function automatic logic [PARAM_W-1:0] pick_param();
    case ($urandom_range(0, 9))
      0: return PARAM_W'($urandom_range(T_ONE + 1, (1 << PARAM_W) - 1));
      1: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return PARAM_W'(1);
          2: return PARAM_W'(T_ONE - 1);
          3: return PARAM_W'(T_ONE);
          default: return '1;
        endcase
      end
      default: return PARAM_W'($urandom_range(0, T_ONE));
    endcase
  endfunction

  // Coordinate mix: full range, extremes and small values of either sign.
  function automatic logic [COORD_W-1:0] pick_coord();
    logic [COORD_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: begin
        v = $urandom_range(0, 32'h00FF_FFFF);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Checks one field of a result against the prediction.
  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result checker: each result transaction against the oldest prediction.
  always @(posedge clk) begin
    curve_sample_t got;
    curve_sample_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[133:0];
      if (pending_samples.size() == 0) begin
        $error("result transaction with no parameter outstanding");
        mismatch_count++;
      end else begin
        want = pending_samples.pop_front();
        check_field("point_x", longint'(want.point_x), longint'(got.point_x));
        check_field("point_y", longint'(want.point_y), longint'(got.point_y));
        check_field("slope_x", longint'(want.slope_x), longint'(got.slope_x));
        check_field("slope_y", longint'(want.slope_y), longint'(got.slope_y));
      end
    end
  end

  // Receiver: random stalls per result, plus a long hold-off on request.
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk);
        sink_hold_cycles = 0;
      end else begin
        stall = sink_stalls_on ? $urandom_range(0, 14) : 0;
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Registers come out of reset as zero, so every result is zero.
  task automatic test_reset_state();
    send_param('0);
    send_param(PARAM_W'(T_ONE / 2));
    send_param(PARAM_W'(T_ONE));
    send_param('1);
    wait_for_results();
  endtask

  // Ends of the curve, the clamp above one and points just inside the ends.
  task automatic test_curve_ends();
    load_curve('{32'h0001_8000, 32'hFFFD_C000, 32'h000A_0000, 32'h0014_0000,
                 32'hFFE1_8000, 32'h0007_0000, 32'h0064_0000, 32'hFFCE_0000});
    send_param('0);
    send_param(PARAM_W'(1));
    send_param(PARAM_W'(T_ONE / 2));
    send_param(PARAM_W'(T_ONE - 1));
    send_param(PARAM_W'(T_ONE));
    send_param(PARAM_W'(T_ONE + 1));
    send_param('1);
    wait_for_results();
  endtask

  // Extreme control points, where rounding can push the point or slope out.
  task automatic test_saturation();
    load_curve('{default: 32'h7FFF_FFFF});
    send_param(PARAM_W'(21845));
    send_param(PARAM_W'(32768));
    send_param(PARAM_W'(43691));
    send_param(PARAM_W'(12345));
    wait_for_results();
    load_curve('{default: 32'h8000_0000});
    send_param(PARAM_W'(21845));
    send_param(PARAM_W'(32768));
    send_param(PARAM_W'(43691));
    wait_for_results();
    load_curve('{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
    send_param('0);
    send_param(PARAM_W'(T_ONE / 2));
    send_param(PARAM_W'(T_ONE));
    send_param(PARAM_W'(3));
    wait_for_results();
  endtask

  // Random curves and parameters under varying idling on both sides.
  task automatic test_random_curves();
    curve_regs_t pts;
    for (int phase = 0; phase < 6; phase++) begin
      wait_for_results();
      for (int i = 0; i < CFG_REGS; i++) pts[i] = pick_coord();
      load_curve(pts);
      source_gaps_on = (phase % 3) != 1;
      sink_stalls_on = (phase % 3) == 0;
      for (int n = 0; n < 120; n++) begin
        if ($urandom_range(0, 49) == 0) wait_for_results();
        send_param(pick_param());
      end
    end
    wait_for_results();
  endtask

  // The receiver holds off while parameters keep coming, so the pipe fills.
  task automatic test_backpressure();
    source_gaps_on   = 1'b0;
    sink_stalls_on   = 1'b0;
    sink_hold_cycles = 300;
    for (int n = 0; n < 40; n++) send_param(pick_param());
    wait_for_results();
  endtask

  initial begin
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    m_axis_tready    = 1'b0;
    mismatch_count   = 0;
    cycle_count      = 0;
    source_gaps_on   = 1'b1;
    sink_stalls_on   = 1'b1;
    sink_hold_cycles = 0;
    foreach (ctrl_pt[i]) ctrl_pt[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_curve_ends();
    test_saturation();
    test_backpressure();
    test_random_curves();

    // Allow the pipeline to settle before the verdict.
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_samples.size() == 0) begin
      $display("** cubic_bezier_evaluator: PASSED **");
    end else begin
      $display("** cubic_bezier_evaluator: FAILED **");
    end
    $finish;
  end

endmodule

FILE: cubic_bezier_evaluator.f
design/cbe_pkg.sv
design/cbe_weights.sv
design/cbe_axis.sv
design/cubic_bezier_evaluator.sv
verif/cubic_bezier_evaluator_tb.sv
